/* sv/bple_pkg.sv */
// Shared types, constants and number coding functions of the binary proof line encoder.
`default_nettype none

package bple_pkg;

    localparam int VAL_W      = 63;
    localparam int NUM_W      = 63;
    localparam int GRP_W      = 7;
    localparam int MAX_GROUPS = 9;
    localparam int LEN_W      = 4;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    typedef enum logic [2:0] {
        OP_ADD_ID    = 3'd0,
        OP_LIT       = 3'd1,
        OP_END_LITS  = 3'd2,
        OP_HINT      = 3'd3,
        OP_END_ADD   = 3'd4,
        OP_DEL_START = 3'd5,
        OP_DEL_ID    = 3'd6,
        OP_END_DEL   = 3'd7
    } op_t;

    localparam logic CFG_FRAT     = 1'b0;
    localparam logic CFG_BACKWARD = 1'b1;

    localparam logic [7:0] HDR_ADD   = 8'h61;
    localparam logic [7:0] HDR_HINTS = 8'h6c;
    localparam logic [7:0] HDR_DEL   = 8'h64;
    localparam logic [7:0] TERM_BYTE = 8'h00;

    typedef struct packed {
        logic             pre_vld;
        logic [7:0]       pre_byte;
        logic             num_vld;
        logic [NUM_W-1:0] num;
        logic [LEN_W-1:0] num_len;
        logic             post_vld;
        logic [7:0]       post_byte;
        logic             bwd;
    } bple_desc_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } bple_qstat_t;

    typedef struct packed {
        logic pop;
        logic load;
    } bple_bctl_t;

    function automatic logic [NUM_W-1:0] signed_map(input logic [VAL_W-1:0] v);
        logic             neg;
        logic [VAL_W-1:0] neg_v;
        logic [NUM_W-2:0] mag;
        neg   = v[VAL_W-1];
        neg_v = ~v + VAL_W'(1);
        if (!neg) begin
            mag = v[NUM_W-2:0];
        end else if (neg_v[VAL_W-1]) begin
            mag = '1;
        end else begin
            mag = neg_v[NUM_W-2:0];
        end
        return {mag, neg};
    endfunction

    function automatic logic [LEN_W-1:0] group_count(input logic [NUM_W-1:0] u);
        logic [LEN_W-1:0] cnt;
        cnt = LEN_W'(1);
        for (int g = 1; g < MAX_GROUPS; g++) begin
            if (u[g*GRP_W +: GRP_W] != '0) begin
                cnt = LEN_W'(g + 1);
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

/* sv/bple_front.sv */
// Front end: accepts proof tokens and turns each into a byte plan for the back end.
`default_nettype none

module bple_front import bple_pkg::*; (
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        frat_mode,
    input  wire logic        backward_mode,
    input  wire logic        q_full,
    output logic             push,
    output bple_desc_t       desc
);

    logic [VAL_W-1:0] raw;
    logic [NUM_W-1:0] mapped;
    op_t              op;

    assign raw      = s_tdata[VAL_W-1:0];
    assign mapped   = signed_map(raw);
    assign op       = op_t'(s_tuser);
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        desc           = '0;
        desc.bwd       = backward_mode;
        desc.num       = mapped;
        desc.pre_byte  = TERM_BYTE;
        desc.post_byte = TERM_BYTE;
        case (op)
            OP_ADD_ID: begin
                desc.num_vld = 1'b1;
                desc.num     = frat_mode ? raw : mapped;
                if (backward_mode) begin
                    desc.post_vld  = 1'b1;
                    desc.post_byte = HDR_ADD;
                end else begin
                    desc.pre_vld  = 1'b1;
                    desc.pre_byte = HDR_ADD;
                end
            end
            OP_END_LITS: begin
                if (backward_mode) begin
                    desc.pre_vld   = frat_mode;
                    desc.pre_byte  = HDR_HINTS;
                    desc.post_vld  = 1'b1;
                end else begin
                    desc.pre_vld   = 1'b1;
                    desc.post_vld  = frat_mode;
                    desc.post_byte = HDR_HINTS;
                end
            end
            OP_DEL_START: begin
                desc.pre_vld  = 1'b1;
                desc.pre_byte = HDR_DEL;
            end
            OP_END_ADD, OP_END_DEL: begin
                desc.pre_vld = 1'b1;
            end
            OP_LIT, OP_HINT, OP_DEL_ID: begin
                desc.num_vld = 1'b1;
            end
            default: begin
                desc.pre_vld = 1'b1;
            end
        endcase
        desc.num_len = group_count(desc.num);
    end

endmodule

`default_nettype wire

/* sv/bple_queue.sv */
// Short queue of byte plans between the front end and the back end.
`default_nettype none

module bple_queue import bple_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire bple_desc_t  wr_desc,
    input  wire logic        pop,
    output bple_desc_t       head,
    output bple_qstat_t      stat
);

    bple_desc_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/bple_back.sv */
// Back end: walks each byte plan and sends one byte per beat through an output register.
`default_nettype none

module bple_back import bple_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire bple_desc_t  head,
    input  wire logic        head_vld,
    output bple_bctl_t       ctl,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    typedef enum logic [2:0] {
        PH_PRE  = 3'b001,
        PH_NUM  = 3'b010,
        PH_POST = 3'b100
    } phase_t;

    phase_t           phase_reg, phase_next, eff;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic [LEN_W-1:0] gi, len_m1;
    logic [GRP_W-1:0] grp;
    logic [7:0]       cur_byte;
    logic             cur_last, advance;

    assign len_m1 = head.num_len - LEN_W'(1);
    assign gi     = head.bwd ? (len_m1 - cnt_reg) : cnt_reg;

    always_comb begin
        case (phase_reg)
            PH_PRE:  eff = head.pre_vld ? PH_PRE : (head.num_vld ? PH_NUM : PH_POST);
            PH_NUM:  eff = head.num_vld ? PH_NUM : PH_POST;
            PH_POST: eff = PH_POST;
            default: eff = PH_PRE;
        endcase
    end

    always_comb begin
        grp = '0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            if (gi == LEN_W'(g)) begin
                grp = head.num[g*GRP_W +: GRP_W];
            end
        end
    end

    always_comb begin
        case (eff)
            PH_PRE: begin
                cur_byte = head.pre_byte;
                cur_last = !head.num_vld && !head.post_vld;
            end
            PH_NUM: begin
                cur_byte = {gi != len_m1, grp};
                cur_last = (cnt_reg == len_m1) && !head.post_vld;
            end
            PH_POST: begin
                cur_byte = head.post_byte;
                cur_last = 1'b1;
            end
            default: begin
                cur_byte = head.pre_byte;
                cur_last = 1'b1;
            end
        endcase
    end

    assign advance  = head_vld && (!valid_reg || m_tready);
    assign ctl.load = advance;
    assign ctl.pop  = advance && cur_last;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (advance) begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            last_next  = cur_last;
            if (cur_last) begin
                phase_next = PH_PRE;
                cnt_next   = '0;
            end else begin
                case (eff)
                    PH_PRE: begin
                        phase_next = PH_NUM;
                    end
                    PH_NUM: begin
                        if (cnt_reg == len_m1) begin
                            phase_next = PH_POST;
                            cnt_next   = '0;
                        end else begin
                            cnt_next = cnt_reg + LEN_W'(1);
                        end
                    end
                    default: begin
                        phase_next = PH_PRE;
                        cnt_next   = '0;
                    end
                endcase
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PRE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

/* sv/binary_proof_line_encoder.sv */
// Top level of the binary proof line encoder: config registers, front end, queue and back end.
//
//  Channel  Direction  Handshake            Content
//  s_       in         s_tvalid / s_tready  tdata: value[62:0]; tuser: opcode[2:0]
//  m_       out        m_tvalid / m_tready  tdata: out_byte[7:0]; tlast: last
//  cfg_     in         cfg_valid/cfg_ready  cfg_index selects the register, cfg_data holds it
//
// The output sends one byte per cycle while m_tready is high; a token makes 1 to 10 bytes,
// typically 1 to 4. The front end takes one token per cycle while the four-entry queue has
// room; a token's first byte goes through its queue entry and the output register to m_tdata.
// Reset clears both config registers, empties the queue and drops m_tvalid.
// A stalled output keeps its byte and the queue soaks up up to four more tokens.
`default_nettype none

module binary_proof_line_encoder import bple_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // value[62:0], zero in bit 63
    input  wire logic [2:0]  s_tuser,   // opcode[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

    logic        frat_reg, frat_next;
    logic        bwd_reg, bwd_next;
    logic        push;
    bple_desc_t  desc, head;
    bple_qstat_t qstat;
    bple_bctl_t  bctl;

    assign cfg_ready = 1'b1;

    always_comb begin
        frat_next = frat_reg;
        bwd_next  = bwd_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAT:     frat_next = cfg_data;
                CFG_BACKWARD: bwd_next  = cfg_data;
                default:      frat_next = frat_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frat_reg <= 1'b0;
            bwd_reg  <= 1'b0;
        end else begin
            frat_reg <= frat_next;
            bwd_reg  <= bwd_next;
        end
    end

    bple_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .frat_mode     (frat_reg),
        .backward_mode (bwd_reg),
        .q_full        (qstat.full),
        .push          (push),
        .desc          (desc)
    );

    bple_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_desc (desc),
        .pop     (bctl.pop),
        .head    (head),
        .stat    (qstat)
    );

    bple_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .head_vld (!qstat.empty),
        .ctl      (bctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("Queue count exceeds its depth.");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == !qstat.full)
        else $error("Input ready disagrees with the queue state.");

    a_pop_load: assert property (@(posedge aclk) disable iff (!aresetn)
        bctl.pop |-> bctl.load && !qstat.empty)
        else $error("Queue entry retired without a byte from it.");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        bctl.load |=> m_tvalid && (m_tlast == $past(bctl.pop)))
        else $error("Loaded byte or its last flag went missing.");

endmodule

`default_nettype wire

/* sim/bple_stream_checker.sv */
// Stream checker for the binary proof line encoder: predicts the proof bytes and compares each beat.
`timescale 1ns / 100ps

module bple_stream_checker import bple_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,   // value[62:0], zero in bit 63
    input  wire logic [2:0]  s_tuser,   // opcode[2:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // out_byte[7:0]
    input  wire logic        m_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data,
    input  wire logic        run_done,
    output int               mismatch_count,
    output int               bytes_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } proof_byte_t;

    proof_byte_t expected_bytes[$];
    logic        frat_mode;
    logic        backward_mode;
    logic        leftover_checked;

    initial begin
        mismatch_count   = 0;
        bytes_pending    = 0;
        frat_mode        = 1'b0;
        backward_mode    = 1'b0;
        leftover_checked = 1'b0;
    end

    function automatic logic [62:0] signed_code(input logic [62:0] v);
        logic [62:0] neg_v;
        logic [61:0] mag;
        neg_v = -v;
        if (!v[62]) begin
            mag = v[61:0];
        end else if (neg_v[62]) begin
            mag = '1;
        end else begin
            mag = neg_v[61:0];
        end
        return {mag, v[62]};
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        expected_bytes.push_back('{data: b, last: 1'b0});
    endfunction

    function automatic void emit_number(input logic [62:0] u);
        logic [7:0] grp [10];
        int         k;
        k = 0;
        while (u > 63'd127 && k < 9) begin
            grp[k] = {1'b1, u[6:0]};
            k++;
            u = u >> 7;
        end
        grp[k] = u[7:0];
        k++;
        if (backward_mode) begin
            for (int i = k - 1; i >= 0; i--) emit_byte(grp[i]);
        end else begin
            for (int i = 0; i < k; i++) emit_byte(grp[i]);
        end
    endfunction

    function automatic void predict_token(input op_t op, input logic [62:0] val);
        logic [62:0] id_code;
        id_code = frat_mode ? val : signed_code(val);
        case (op)
            OP_ADD_ID: begin
                if (backward_mode) begin
                    emit_number(id_code);
                    emit_byte(HDR_ADD);
                end else begin
                    emit_byte(HDR_ADD);
                    emit_number(id_code);
                end
            end
            OP_END_LITS: begin
                if (backward_mode) begin
                    if (frat_mode) emit_byte(HDR_HINTS);
                    emit_byte(TERM_BYTE);
                end else begin
                    emit_byte(TERM_BYTE);
                    if (frat_mode) emit_byte(HDR_HINTS);
                end
            end
            OP_DEL_START: begin
                emit_byte(HDR_DEL);
            end
            OP_END_ADD, OP_END_DEL: begin
                emit_byte(TERM_BYTE);
            end
            default: begin
                emit_number(signed_code(val));
            end
        endcase
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        proof_byte_t want;
        if (!aresetn) begin
            expected_bytes.delete();
            frat_mode     = 1'b0;
            backward_mode = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, byte %02h", m_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data) begin
                        report_mismatch($sformatf("byte %02h, want %02h", m_tdata, want.data));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("tlast %b, want %b on byte %02h",
                                                  m_tlast, want.last, want.data));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAT) begin
                    frat_mode = cfg_data;
                end else begin
                    backward_mode = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_token(op_t'(s_tuser), s_tdata[62:0]);
            end
            if (run_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (expected_bytes.size() != 0) begin
                    report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
                end
            end
        end
        bytes_pending = expected_bytes.size();
    end

endmodule

/* sim/tb.sv */
// Testbench top for the binary proof line encoder: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
    import bple_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 20;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [62:0] MAG_MAX   = 63'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] NEG_MAX   = 63'h4000_0000_0000_0001;
    localparam logic [62:0] NEG_MIN   = 63'h4000_0000_0000_0000;
    localparam logic [62:0] MINUS_ONE = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        op_t         op;
        logic [62:0] val;
    } proof_token_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        run_done  = 1'b0;
    wire logic       s_tready;
    wire logic       m_tvalid;
    wire logic [7:0] m_tdata;
    wire logic       m_tlast;
    wire logic       cfg_ready;

    int   mismatch_count;
    int   bytes_pending;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_req     = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;
    int   idle_cycles  = 0;
    logic bwd_now      = 1'b0;

    proof_token_t line_q[$];

    always #HALF_PERIOD aclk = ~aclk;

    binary_proof_line_encoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bple_stream_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .run_done       (run_done),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending)
    );

    // A toggle of hold_req starts one long hold-off of the output.
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("binary_proof_line_encoder regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_token(input op_t op, input logic [62:0] val);
        int gap;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, val};
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (bytes_pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_mode(input logic frat, input logic bwd);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAT;
        cfg_data  <= frat;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_index <= CFG_BACKWARD;
        cfg_data  <= bwd;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        bwd_now = bwd;
    endtask

    // Mostly short magnitudes, with the range limits and raw patterns mixed in.
    function automatic logic [62:0] random_value();
        logic [63:0] r;
        logic [61:0] mag;
        int          w;
        r   = {$urandom, $urandom};
        w   = ($urandom_range(99) < 70) ? $urandom_range(1, 14) : $urandom_range(15, 62);
        mag = r[61:0] & ((62'd1 << w) - 62'd1);
        case ($urandom_range(19))
            0:       return NEG_MIN;
            1:       return MAG_MAX;
            2:       return NEG_MAX;
            3:       return r[62:0];
            default: return r[63] ? -{1'b0, mag} : {1'b0, mag};
        endcase
    endfunction

    function automatic void add_to_line(input op_t op, input logic [62:0] val);
        if (bwd_now) begin
            line_q.push_front('{op: op, val: val});
        end else begin
            line_q.push_back('{op: op, val: val});
        end
    endfunction

    // Backward mode wants the tokens of a line in reverse order.
    function automatic void compose_line();
        int roll;
        line_q.delete();
        roll = $urandom_range(99);
        if (roll < 15) begin
            repeat ($urandom_range(1, 3)) add_to_line(op_t'($urandom_range(7)), random_value());
        end else if (roll < 75) begin
            add_to_line(OP_ADD_ID, random_value());
            repeat ($urandom_range(0, 4)) add_to_line(OP_LIT, random_value());
            add_to_line(OP_END_LITS, random_value());
            repeat ($urandom_range(0, 5)) add_to_line(OP_HINT, random_value());
            add_to_line(OP_END_ADD, random_value());
        end else begin
            add_to_line(OP_DEL_START, random_value());
            repeat ($urandom_range(1, 3)) add_to_line(OP_DEL_ID, random_value());
            add_to_line(OP_END_DEL, random_value());
        end
    endfunction

    initial begin
        int sent;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_token(OP_ADD_ID, 63'd1);
        send_token(OP_LIT, 63'd63);
        send_token(OP_LIT, -63'd64);
        send_token(OP_LIT, MAG_MAX);
        send_token(OP_LIT, NEG_MIN);
        send_token(OP_END_LITS, MINUS_ONE);
        send_token(OP_HINT, NEG_MAX);
        send_token(OP_HINT, 63'd0);
        send_token(OP_END_ADD, 63'd0);
        send_token(OP_DEL_START, MAG_MAX);
        send_token(OP_DEL_ID, 63'd64);
        send_token(OP_END_DEL, 63'd0);

        set_mode(1'b1, 1'b1);
        send_token(OP_END_ADD, 63'd0);
        send_token(OP_HINT, 63'd5);
        send_token(OP_END_LITS, 63'd0);
        send_token(OP_LIT, MINUS_ONE);
        send_token(OP_ADD_ID, MINUS_ONE);
        send_token(OP_ADD_ID, NEG_MIN);
        send_token(OP_ADD_ID, 63'd0);
        send_token(OP_END_DEL, 63'd0);
        send_token(OP_DEL_ID, MAG_MAX);
        send_token(OP_DEL_START, 63'd0);

        for (int p = 0; p < 8; p++) begin
            set_mode(p[0], p[1]);
            case ((p + p / 4) % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 50;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 50;
                end
                default: begin
                    tx_idle_pct = 9;
                    rx_stall_pct <= 9;
                end
            endcase
            if (p == 0) hold_req <= ~hold_req;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                compose_line();
                foreach (line_q[i]) send_token(line_q[i].op, line_q[i].val);
                sent += line_q.size();
            end
        end

        s_tvalid <= 1'b0;
        while (bytes_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        run_done <= 1'b1;
        repeat (2) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("binary_proof_line_encoder regression: pass");
        end else begin
            $display("binary_proof_line_encoder regression: fail");
        end
        $finish;
    end

endmodule
